// File: rtl/core/multi_heap_slot_allocator_assert.svh
// Assertion macros shared by the slot allocator RTL.
`ifndef MULTI_HEAP_SLOT_ALLOCATOR_ASSERT_SVH
`define MULTI_HEAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MHSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MHSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mhsa_pkg.sv
// Types, constants and codes shared by the slot allocator modules.
package mhsa_pkg;

    localparam int MHSA_MAX_HEAPS      = 8;
    localparam int MHSA_SLOTS_PER_HEAP = 256;
    localparam int MAP_WORD_W          = 64;
    localparam int MAP_POS_W           = 6;
    localparam int CFG_W               = 9;
    localparam int COUNT_MAX           = 511;
    localparam int STRIDE_MAX          = 256;
    localparam int SPH_RESET           = 256;
    localparam int STRIDE_RESET        = 32;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;
    localparam int HEAP_W      = 3;
    localparam int SLOT_W      = 8;
    localparam int OFFSET_W    = 16;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_NO_SLOT,
        STAT_BAD_FREE,
        STAT_DOUBLE_FREE
    } t_status;

    typedef enum logic {
        REQ_ALLOC,
        REQ_FREE
    } t_req;

    typedef enum logic {
        CFG_SLOTS_PER_HEAP,
        CFG_DESC_STRIDE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_HEAP,
        S_SCAN_WORD,
        S_CLEAR,
        S_FREE_WORD,
        S_DONE
    } t_state;

    // result of the find-first-zero unit
    typedef struct packed {
        logic                 hit;
        logic [MAP_POS_W-1:0] pos;
    } t_ffz;

endpackage

// File: rtl/core/multi_heap_slot_allocator.sv
// Top level of the multi-heap first-fit slot allocator.
//
// Requests arrive as words on the s_axis channel: tuser says allocate or
// free, tdata carries the heap and slot to free. Each request yields one
// result word on m_axis: tuser holds the status, tdata the granted heap,
// slot, byte offset and the opened-heap flag. Two registers (slots per
// heap, descriptor stride) are written through the plain cfg port, by the
// user only while the block is idle; the block itself does not enforce it.
// Timing: one request is in flight at a time; s_axis_tready is high only
// while idle. A free reads its bitmap word and writes it back; one rejected
// for a bad heap or slot goes straight to the result. An allocate passes
// over heaps whose count is zero and reads bitmap words one at a time (a heap
// whose count proves stale costs its reads too); opening a new heap clears
// its ceil(SLOTS_PER_HEAP/64) bitmap words instead of the word reads. The
// result word turns valid in the same cycle that tready rises again. The
// single bitmap RAM port and the find-first-zero unit set this sequence.
// Reset clears the heap count and free counts and restores the register
// defaults; the bitmap RAM needs no clearing as a heap's words are zeroed
// when it is opened. A stalled receiver holds the result in the output
// register; a new request is still taken, but its result waits behind it.
`include "multi_heap_slot_allocator_assert.svh"

module multi_heap_slot_allocator #(
    parameter int MAX_HEAPS      = mhsa_pkg::MHSA_MAX_HEAPS,
    parameter int SLOTS_PER_HEAP = mhsa_pkg::MHSA_SLOTS_PER_HEAP
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [mhsa_pkg::CFG_W-1:0]         i_cfg_wdata,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mhsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // heap_number[2:0], slot_number[10:3]
    input  logic [mhsa_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // req_type[0]
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mhsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // granted_heap[2:0], granted_slot[10:3],
                                                              // byte_offset[26:11], opened_heap[27]
    output logic [mhsa_pkg::OUT_TUSER_W-1:0]   m_axis_tuser   // status[1:0]
);
    import mhsa_pkg::*;

    localparam int WORDS = (SLOTS_PER_HEAP + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int DEPTH = MAX_HEAPS * WORDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW    = $clog2(MAX_HEAPS + 1);
    localparam int HW    = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
    localparam int SW    = ($clog2(SLOTS_PER_HEAP + 1) > CFG_W) ?
                           $clog2(SLOTS_PER_HEAP + 1) : CFG_W;
    localparam int IW    = SW + 1;
    localparam int WCW   = $clog2(WORDS + 1);
    localparam int CMPW  = (OW > HEAP_W) ? OW : HEAP_W;
    localparam int PW    = IW + CFG_W;

    // control state
    t_state              r_state, n_state;
    logic [OW-1:0]       r_heaps_open, n_heaps_open;
    logic [SW-1:0]       r_count [MAX_HEAPS];
    logic [SW-1:0]       n_count [MAX_HEAPS];
    logic [CFG_W-1:0]    r_cfg_sph, r_cfg_stride;
    logic                r_out_valid, n_out_valid;

    // working registers of the current request
    logic [SW-1:0]       r_sph, n_sph;
    logic [CFG_W-1:0]    r_stride, n_stride;
    logic [OW-1:0]       r_heap, n_heap;
    logic [WCW-1:0]      r_word, n_word;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [IW-1:0]       r_found, n_found;
    t_status             r_status, n_status;
    logic                r_opened, n_opened;
    logic                r_is_free, n_is_free;

    // output register
    t_status             r_out_status, n_out_status;
    logic [HEAP_W-1:0]   r_out_heap, n_out_heap;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [OFFSET_W-1:0] r_out_offset, n_out_offset;
    logic                r_out_opened, n_out_opened;

    // bitmap RAM
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [MAP_WORD_W-1:0] ram_wdata, ram_rdata;

    logic [SW-1:0]       c_sph;
    logic [CFG_W-1:0]    c_stride;
    logic [HEAP_W-1:0]   c_in_heap;
    logic [SLOT_W-1:0]   c_in_slot;
    logic [WCW-1:0]      c_word_next;
    logic [IW-1:0]       c_base, c_idx;
    t_ffz                c_ffz;
    logic [PW-1:0]       c_prod;
    logic                c_out_free;

    function automatic logic [AW-1:0] f_addr(input logic [OW-1:0] h, input logic [WCW-1:0] w);
        return AW'(h) * AW'(WORDS) + AW'(w);
    endfunction

    assign c_in_heap = s_axis_tdata[HEAP_W-1:0];
    assign c_in_slot = s_axis_tdata[HEAP_W +: SLOT_W];

    // registers are used saturated: zero acts as one, above range as the maximum
    always_comb begin
        if (r_cfg_sph == '0) begin
            c_sph = SW'(1);
        end else if (SW'(r_cfg_sph) > SW'(SLOTS_PER_HEAP)) begin
            c_sph = SW'(SLOTS_PER_HEAP);
        end else begin
            c_sph = SW'(r_cfg_sph);
        end
        if (r_cfg_stride == '0) begin
            c_stride = CFG_W'(1);
        end else if (r_cfg_stride > CFG_W'(STRIDE_MAX)) begin
            c_stride = CFG_W'(STRIDE_MAX);
        end else begin
            c_stride = r_cfg_stride;
        end
    end

    assign c_base      = IW'(r_word) << MAP_POS_W;
    assign c_word_next = r_word + WCW'(1);
    assign c_prod      = PW'(r_found) * PW'(r_stride);
    assign c_out_free  = !r_out_valid || m_axis_tready;

    mhsa_scan #(
        .IW (IW)
    ) u_scan (
        .i_word  (ram_rdata),
        .i_base  (c_base),
        .i_limit (IW'(r_sph)),
        .o_res   (c_ffz),
        .o_idx   (c_idx)
    );

    mhsa_ram #(
        .WIDTH (MAP_WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer: next state, datapath updates, RAM controls
    always_comb begin
        n_state      = r_state;
        n_heaps_open = r_heaps_open;
        n_count      = r_count;
        n_sph        = r_sph;
        n_stride     = r_stride;
        n_heap       = r_heap;
        n_word       = r_word;
        n_slot       = r_slot;
        n_found      = r_found;
        n_status     = r_status;
        n_opened     = r_opened;
        n_is_free    = r_is_free;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_heap   = r_out_heap;
        n_out_slot   = r_out_slot;
        n_out_offset = r_out_offset;
        n_out_opened = r_out_opened;
        ram_we       = 1'b0;
        ram_waddr    = f_addr(r_heap, r_word);
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = f_addr(r_heap, r_word);
        s_axis_tready = 1'b0;

        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_sph     = c_sph;
                    n_stride  = c_stride;
                    n_found   = '0;
                    n_opened  = 1'b0;
                    n_status  = STAT_OK;
                    n_is_free = (s_axis_tuser[0] == REQ_FREE);
                    if (s_axis_tuser[0] == REQ_FREE) begin
                        n_slot = c_in_slot;
                        n_heap = OW'(c_in_heap);
                        n_word = WCW'(c_in_slot >> MAP_POS_W);
                        if ((CMPW'(c_in_heap) >= CMPW'(r_heaps_open)) ||
                            (SW'(c_in_slot) >= c_sph)) begin
                            n_status = STAT_BAD_FREE;
                            n_state  = S_DONE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = f_addr(OW'(c_in_heap),
                                               WCW'(c_in_slot >> MAP_POS_W));
                            n_state   = S_FREE_WORD;
                        end
                    end else begin
                        n_heap  = '0;
                        n_state = S_SCAN_HEAP;
                    end
                end
            end

            S_SCAN_HEAP: begin
                if (r_heap < r_heaps_open) begin
                    if (r_count[r_heap[HW-1:0]] == '0) begin
                        n_heap = r_heap + OW'(1);
                    end else begin
                        n_word    = '0;
                        ram_re    = 1'b1;
                        ram_raddr = f_addr(r_heap, '0);
                        n_state   = S_SCAN_WORD;
                    end
                end else if (r_heaps_open == OW'(MAX_HEAPS)) begin
                    n_status = STAT_NO_SLOT;
                    n_state  = S_DONE;
                end else begin
                    // every open heap is full: open the next one
                    n_word  = '0;
                    n_state = S_CLEAR;
                end
            end

            S_SCAN_WORD: begin
                if (c_ffz.hit) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (MAP_WORD_W'(1) << c_ffz.pos);
                    n_count[r_heap[HW-1:0]] = r_count[r_heap[HW-1:0]] - SW'(1);
                    n_found   = c_idx;
                    n_state   = S_DONE;
                end else if ((c_word_next < WCW'(WORDS)) &&
                             ((IW'(c_word_next) << MAP_POS_W) < IW'(r_sph))) begin
                    n_word    = c_word_next;
                    ram_re    = 1'b1;
                    ram_raddr = f_addr(r_heap, c_word_next);
                end else begin
                    // nothing free below the limit: count was stale
                    n_count[r_heap[HW-1:0]] = '0;
                    n_heap  = r_heap + OW'(1);
                    n_state = S_SCAN_HEAP;
                end
            end

            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_word == '0) ? MAP_WORD_W'(1) : '0;
                if (c_word_next == WCW'(WORDS)) begin
                    n_heaps_open = r_heaps_open + OW'(1);
                    n_count[r_heap[HW-1:0]] = r_sph - SW'(1);
                    n_found  = '0;
                    n_opened = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_word = c_word_next;
                end
            end

            S_FREE_WORD: begin
                if (!ram_rdata[r_slot[MAP_POS_W-1:0]]) begin
                    n_status = STAT_DOUBLE_FREE;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata & ~(MAP_WORD_W'(1) << r_slot[MAP_POS_W-1:0]);
                    if (r_count[r_heap[HW-1:0]] < SW'(COUNT_MAX)) begin
                        n_count[r_heap[HW-1:0]] = r_count[r_heap[HW-1:0]] + SW'(1);
                    end
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (c_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    if (r_status == STAT_OK && !r_is_free) begin
                        n_out_heap   = HEAP_W'(r_heap);
                        n_out_slot   = r_found[SLOT_W-1:0];
                        n_out_offset = c_prod[OFFSET_W-1:0];
                        n_out_opened = r_opened;
                    end else begin
                        n_out_heap   = '0;
                        n_out_slot   = '0;
                        n_out_offset = '0;
                        n_out_opened = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heaps_open <= '0;
            r_out_valid  <= 1'b0;
            r_cfg_sph    <= CFG_W'(SPH_RESET);
            r_cfg_stride <= CFG_W'(STRIDE_RESET);
            for (int h = 0; h < MAX_HEAPS; h++) begin
                r_count[h] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_heaps_open <= n_heaps_open;
            r_out_valid  <= n_out_valid;
            r_count      <= n_count;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SLOTS_PER_HEAP: r_cfg_sph    <= i_cfg_wdata;
                    CFG_DESC_STRIDE:    r_cfg_stride <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sph        <= n_sph;
        r_stride     <= n_stride;
        r_heap       <= n_heap;
        r_word       <= n_word;
        r_slot       <= n_slot;
        r_found      <= n_found;
        r_status     <= n_status;
        r_opened     <= n_opened;
        r_is_free    <= n_is_free;
        r_out_status <= n_out_status;
        r_out_heap   <= n_out_heap;
        r_out_slot   <= n_out_slot;
        r_out_offset <= n_out_offset;
        r_out_opened <= n_out_opened;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(OUT_TDATA_W - HEAP_W - SLOT_W - OFFSET_W - 1)'(0),
                            r_out_opened, r_out_offset, r_out_slot, r_out_heap};

    `MHSA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "request taken while another is in flight")
    `MHSA_ASSERT_NOW(a_heaps_bounded, i_clk, i_rst_n,
        1'b1, r_heaps_open <= OW'(MAX_HEAPS),
        "more heaps open than exist")
    `MHSA_ASSERT_NOW(a_exhaust_all_open, i_clk, i_rst_n,
        r_out_valid && (r_out_status == STAT_NO_SLOT), r_heaps_open == OW'(MAX_HEAPS),
        "exhaustion reported with a heap still unopened")
    `MHSA_ASSERT_NOW(a_open_gives_slot0, i_clk, i_rst_n,
        r_out_valid && r_out_opened, (r_out_slot == '0) && (r_out_offset == '0),
        "new heap did not grant its first slot")

endmodule

// File: rtl/core/mhsa_ram.sv
// Generic simple dual-port RAM with registered read.
module mhsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mhsa_scan.sv
// Find-first-zero unit: lowest free slot of one bitmap word, bounded by the slot limit.
module mhsa_scan #(
    parameter int IW = 10
) (
    input  logic [mhsa_pkg::MAP_WORD_W-1:0] i_word,
    input  logic [IW-1:0]                   i_base,
    input  logic [IW-1:0]                   i_limit,
    output mhsa_pkg::t_ffz                  o_res,
    output logic [IW-1:0]                   o_idx
);
    import mhsa_pkg::*;

    logic                 c_any;
    logic [MAP_POS_W-1:0] c_pos;

    // priority pick, lowest clear bit wins
    always_comb begin
        c_any = 1'b0;
        c_pos = '0;
        for (int i = MAP_WORD_W - 1; i >= 0; i--) begin
            if (!i_word[i]) begin
                c_any = 1'b1;
                c_pos = MAP_POS_W'(i);
            end
        end
    end

    assign o_idx     = i_base + IW'(c_pos);
    assign o_res.pos = c_pos;
    assign o_res.hit = c_any && (o_idx < i_limit);

endmodule
